>>> hw/rtl/fixed_point_binary_log_defines.svh
// Assertion macros used by the port-level checker of the binary log block.
`ifndef FIXED_POINT_BINARY_LOG_DEFINES_SVH
`define FIXED_POINT_BINARY_LOG_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define FPBL_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FPBL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/fpbl_pkg.sv
// Package with widths, constants and the stage record of the binary log pipeline.
package fpbl_pkg;

  // Operand format: unsigned, IN_FRAC fraction bits.
  localparam int unsigned IN_WIDTH = 32;
  localparam int unsigned IN_FRAC  = 16;
  // Default number of result fraction bits (one squaring stage each).
  localparam int unsigned OUT_FRAC = 16;

  // Result word width.
  localparam int unsigned LOG_W  = 32;
  // Mantissa in [1,2): one integer bit plus IN_FRAC fraction bits.
  localparam int unsigned MANT_W = IN_FRAC + 1;
  // Leading-zero count and signed exponent widths.
  localparam int unsigned LZ_W   = $clog2(IN_WIDTH);
  localparam int unsigned EXP_W  = LZ_W + 1;

  // Result for a zero operand, and the saturation limits.
  localparam logic [LOG_W-1:0] LOG_MIN = {1'b1, {(LOG_W-1){1'b0}}};
  localparam logic [LOG_W-1:0] LOG_MAX = {1'b0, {(LOG_W-1){1'b1}}};

  // Record that travels down the pipeline with each item.
  typedef struct packed {
    logic                    zero;
    logic signed [EXP_W-1:0] expo;
    logic [MANT_W-1:0]       mant;
  } fpbl_item_t;

endpackage

>>> hw/rtl/fixed_point_binary_log.sv
// Top level of the pipelined fixed-point binary logarithm.
//
//   Channel   Direction  tdata                 tuser
//   s_axis    in         operand [31:0]        -
//   m_axis    out        log_value [31:0]      zero_input [0]
//
// The pipeline has two normalizer stages, one squaring stage per
// fraction bit, and the output register. A new transaction can be taken every cycle while
// the sink does not stall; each squaring multiplier sets the clock period.
// Reset clears only the valid bits. When the sink stalls, the whole pipeline
// holds, so no item is lost or repeated.
module fixed_point_binary_log
  import fpbl_pkg::*;
#(
  parameter int unsigned OutFrac = OUT_FRAC
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [31:0]      s_axis_tdata,   // [31:0] operand
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [LOG_W-1:0] m_axis_tdata,   // [31:0] log_value
  output logic [0:0]       m_axis_tuser    // [0] zero_input
);

  logic               en;
  logic               valid_c [OutFrac+1];
  fpbl_item_t         item_c  [OutFrac+1];
  logic [OutFrac-1:0] frac_c  [OutFrac+1];

  assign s_axis_tready = en;
  assign frac_c[0]     = '0;

  // Normalization into [1,2) with the integer part of the result.
  fpbl_norm u_norm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (s_axis_tvalid),
    .operand_i (s_axis_tdata[IN_WIDTH-1:0]),
    .valid_o   (valid_c[0]),
    .item_o    (item_c[0])
  );

  // One squaring stage per fraction bit, most significant bit first.
  for (genvar k = 0; k < OutFrac; k++) begin : g_sq
    fpbl_sq_stage #(
      .OutFrac (OutFrac),
      .BitIdx  (OutFrac - 1 - k)
    ) u_sq (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_c[k]),
      .item_i  (item_c[k]),
      .frac_i  (frac_c[k]),
      .valid_o (valid_c[k+1]),
      .item_o  (item_c[k+1]),
      .frac_o  (frac_c[k+1])
    );
  end

  // Result assembly, saturation and output register.
  fpbl_out #(
    .OutFrac (OutFrac)
  ) u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_c[OutFrac]),
    .item_i       (item_c[OutFrac]),
    .frac_i       (frac_c[OutFrac]),
    .en_o         (en),
    .valid_o      (m_axis_tvalid),
    .log_value_o  (m_axis_tdata),
    .zero_input_o (m_axis_tuser[0]),
    .ready_i      (m_axis_tready)
  );

endmodule

>>> hw/rtl/fpbl_norm.sv
// Two-stage normalizer: leading-zero count, then shift into [1,2).
module fpbl_norm
  import fpbl_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [IN_WIDTH-1:0] operand_i,
  output logic                valid_o,
  output fpbl_item_t          item_o
);

  logic                valid1_q;
  logic [IN_WIDTH-1:0] x1_q;
  logic [LZ_W-1:0]     lz1_d, lz1_q;
  logic                zero1_q;
  logic                valid2_q;
  fpbl_item_t          item2_d, item2_q;
  logic [IN_WIDTH-1:0] shifted;

  // Leading-zero count; the highest set bit wins.
  always_comb begin
    lz1_d = '0;
    for (int i = 0; i < IN_WIDTH; i++) begin
      if (operand_i[i]) begin
        lz1_d = LZ_W'(IN_WIDTH - 1 - i);
      end
    end
  end

  // Stage one registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      x1_q    <= operand_i;
      lz1_q   <= lz1_d;
      zero1_q <= (operand_i == '0);
    end
  end

  // Shifting the leading one to the top leaves the mantissa in the upper bits;
  // right shifts of the model drop the same low bits.
  always_comb begin
    shifted       = x1_q << lz1_q;
    item2_d.zero  = zero1_q;
    item2_d.expo  = $signed(EXP_W'(IN_WIDTH - 1 - IN_FRAC)) - $signed({1'b0, lz1_q});
    item2_d.mant  = shifted[IN_WIDTH-1 -: MANT_W];
  end

  // Stage two registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid2_q <= 1'b0;
    end else if (en_i) begin
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid1_q) begin
      item2_q <= item2_d;
    end
  end

  assign valid_o = valid2_q;
  assign item_o  = item2_q;

endmodule

>>> hw/rtl/fpbl_sq_stage.sv
// One squaring stage: square the mantissa, renormalize, and decide one fraction bit.
module fpbl_sq_stage
  import fpbl_pkg::*;
#(
  parameter int unsigned OutFrac = OUT_FRAC,
  parameter int unsigned BitIdx  = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  fpbl_item_t         item_i,
  input  logic [OutFrac-1:0] frac_i,
  output logic               valid_o,
  output fpbl_item_t         item_o,
  output logic [OutFrac-1:0] frac_o
);

  logic [2*MANT_W-1:0] square;
  logic [MANT_W:0]     sq_trunc;
  fpbl_item_t          item_d, item_q;
  logic [OutFrac-1:0]  frac_d, frac_q;
  logic                valid_q;

  // Square truncated back to IN_FRAC fraction bits lies in [1,4).
  always_comb begin
    square   = item_i.mant * item_i.mant;
    sq_trunc = square[IN_FRAC +: MANT_W+1];
    item_d   = item_i;
    frac_d   = frac_i;
    if (sq_trunc[MANT_W]) begin
      item_d.mant    = sq_trunc[MANT_W:1];
      frac_d[BitIdx] = 1'b1;
    end else begin
      item_d.mant = sq_trunc[MANT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && valid_i) begin
      item_q <= item_d;
      frac_q <= frac_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign frac_o  = frac_q;

endmodule

>>> hw/rtl/fpbl_out.sv
// Output stage: assembles and saturates the result and holds it for the sink.
module fpbl_out
  import fpbl_pkg::*;
#(
  parameter int unsigned OutFrac = OUT_FRAC
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  fpbl_item_t         item_i,
  input  logic [OutFrac-1:0] frac_i,
  output logic               en_o,
  output logic               valid_o,
  output logic [LOG_W-1:0]   log_value_o,
  output logic               zero_input_o,
  input  logic               ready_i
);

  logic signed [EXP_W+OutFrac-1:0] joined;
  logic signed [63:0]              wide;
  logic [LOG_W-1:0]                log_d, log_q;
  logic                            zero_q;
  logic                            valid_q;

  // The pipeline moves whenever the output register is free or being drained.
  assign en_o = !valid_q || ready_i;

  // Exponent and fraction bits side by side form the fixed-point result.
  always_comb begin
    joined = $signed({item_i.expo, frac_i});
    wide   = 64'(joined);
    if (item_i.zero) begin
      log_d = LOG_MIN;
    end else if (wide > $signed({32'd0, LOG_MAX})) begin
      log_d = LOG_MAX;
    end else if (wide < $signed({{32{1'b1}}, LOG_MIN})) begin
      log_d = LOG_MIN;
    end else begin
      log_d = wide[LOG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o && valid_i) begin
      log_q  <= log_d;
      zero_q <= item_i.zero;
    end
  end

  assign valid_o      = valid_q;
  assign log_value_o  = log_q;
  assign zero_input_o = zero_q;

endmodule

>>> hw/rtl/fpbl_checker.sv
// Port-level checker for the binary log block, bound to the top level.
`include "fixed_point_binary_log_defines.svh"

module fpbl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // A zero operand always reports the most negative value.
  `FPBL_ASSERT_SAME(a_zero_min, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 32'h80000000, "zero flag without minimum result")

  // A stalled output stalls the input side as well.
  `FPBL_ASSERT_SAME(a_stall_back, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken while output stalled")

  // A waiting result stays offered.
  `FPBL_ASSERT_NEXT(a_valid_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result withdrawn before transaction")

endmodule

bind fixed_point_binary_log fpbl_checker u_fpbl_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> verif/fixed_point_binary_log_checker.sv
// Checker that predicts and compares the results of the binary log block.
`timescale 1ns / 1ps

module fixed_point_binary_log_checker
  import fpbl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [31:0]      in_operand_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [LOG_W-1:0] out_log_i,
  input  logic             out_zero_i,
  output int               error_count_o,
  output int               pending_o
);

  // One predicted result of the logarithm.
  typedef struct packed {
    logic [LOG_W-1:0] log_value;
    logic             zero_input;
  } log_result_t;

  log_result_t expected_logs_q[$];

  // Base-2 logarithm by normalization and repeated squaring of the mantissa.
  function automatic log_result_t predict_log2(input logic [31:0] operand);
    logic [63:0]        arg;
    logic [63:0]        mant;
    logic [127:0]       square;
    logic signed [63:0] acc;
    int                 lead;
    int                 expo;
    int                 bit_pos;
    log_result_t        res;
    arg = 64'(operand) & ((64'd1 << IN_WIDTH) - 64'd1);
    res.zero_input = (arg == '0);
    res.log_value  = LOG_MIN;
    if (!res.zero_input) begin
      lead = 63;
      while (!arg[lead]) lead--;
      // Bring the mantissa into [1,2); a right shift drops the low bits.
      if (lead >= int'(IN_FRAC)) begin
        mant = arg >> (lead - int'(IN_FRAC));
      end else begin
        mant = arg << (int'(IN_FRAC) - lead);
      end
      expo = lead - int'(IN_FRAC);
      acc  = expo;
      acc  = acc * (64'sd1 <<< OUT_FRAC);
      // Each squaring yields one fraction bit, most significant first.
      for (bit_pos = int'(OUT_FRAC) - 1; bit_pos >= 0; bit_pos--) begin
        square = 128'(mant) * 128'(mant);
        mant   = 64'(square >> IN_FRAC);
        if (mant >= (64'd2 << IN_FRAC)) begin
          mant = mant >> 1;
          acc  = acc + (64'sd1 <<< bit_pos);
        end
      end
      // Out-of-range results clamp to the word limits.
      if (acc > 64'sd2147483647) begin
        res.log_value = LOG_MAX;
      end else if (acc < -64'sd2147483648) begin
        res.log_value = LOG_MIN;
      end else begin
        res.log_value = acc[LOG_W-1:0];
      end
    end
    return res;
  endfunction

  // Predict on each input transaction, compare on each output transaction.
  always @(posedge clk_i) begin
    log_result_t want;
    if (!rst_ni) begin
      error_count_o = 0;
      pending_o     = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        expected_logs_q.push_back(predict_log2(in_operand_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_logs_q.size() == 0) begin
          $error("unexpected result: log_value %h zero_input %b", out_log_i, out_zero_i);
          error_count_o++;
        end else begin
          want = expected_logs_q.pop_front();
          if (out_log_i !== want.log_value) begin
            $error("log_value: expected %h, got %h", want.log_value, out_log_i);
            error_count_o++;
          end
          if (out_zero_i !== want.zero_input) begin
            $error("zero_input: expected %b, got %b", want.zero_input, out_zero_i);
            error_count_o++;
          end
        end
      end
      pending_o = expected_logs_q.size();
    end
  end

endmodule

>>> verif/fixed_point_binary_log_tb.sv
// Testbench top that drives operands into the binary log block and gives the verdict.
`timescale 1ns / 1ps

module fixed_point_binary_log_tb;
  import fpbl_pkg::*;

  localparam int RESET_CYCLES  = 6;
  localparam int RANDOM_ITEMS  = 2000;
  localparam int NUM_PHASES    = 3;
  localparam int DRAIN_CYCLES  = OUT_FRAC + 3 + 8;
  localparam int QUIET_LIMIT   = 5000;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [31:0]      s_axis_tdata  = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [LOG_W-1:0] m_axis_tdata;
  logic [0:0]       m_axis_tuser;

  int error_count;
  int pending_logs;
  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int quiet_cycles  = 0;

  fixed_point_binary_log DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  fixed_point_binary_log_checker log_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_i    (s_axis_tready),
    .in_operand_i  (s_axis_tdata),
    .out_valid_i   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_log_i     (m_axis_tdata),
    .out_zero_i    (m_axis_tuser[0]),
    .error_count_o (error_count),
    .pending_o     (pending_logs)
  );

  always #1 clk_i = ~clk_i;

  // The sink stalls at random according to the current phase.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // Abort when no transaction moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Present one operand, with random gaps before it, and wait for its transaction.
  task automatic send_operand(input logic [31:0] operand);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= operand;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Random operands: full-range words, words with many leading zeros so that
  // every normalization shift occurs, values near powers of two, and zero.
  function automatic logic [31:0] random_operand();
    logic [31:0] word;
    int          pick;
    pick = $urandom_range(0, 19);
    word = $urandom();
    if (pick == 0) begin
      word = '0;
    end else if (pick <= 3) begin
      word = (32'd1 << $urandom_range(0, 31)) + 32'($urandom_range(0, 6)) - 32'd3;
    end else if (pick <= 11) begin
      word = word >> $urandom_range(0, 31);
    end
    return word;
  endfunction

  initial begin
    logic [31:0] directed_ops[$];
    int          phase;
    int          n;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero operand, the extremes, exact powers of two, right and left
    // normalization, and mantissas close to the squaring threshold.
    directed_ops = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h0001_0000, 32'h0000_8000, 32'h0002_0000,
                     32'h0000_FFFF, 32'h0001_0001, 32'h0001_FFFF, 32'h0001_8000,
                     32'h0001_6A09, 32'h0001_6A0A, 32'h0000_0002, 32'h0000_0003,
                     32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000, 32'h00FF_00FF};
    src_idle_pct  = 24;
    sink_idle_pct = 47;
    foreach (directed_ops[i]) send_operand(directed_ops[i]);

    // Random part in three pacing phases.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 24;
          sink_idle_pct = 47;
        end
        1: begin
          src_idle_pct  = 47;
          sink_idle_pct = 24;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      for (n = 0; n < RANDOM_ITEMS / NUM_PHASES; n++) send_operand(random_operand());
    end
    s_axis_tvalid <= 1'b0;

    // Let every expected result arrive, then watch a little longer.
    @(posedge clk_i);
    while (pending_logs != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0 && pending_logs == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
